// ===== sv/vsr_pkg.sv =====
// ---------------------------------------------------------------------------
// vsr_pkg
// Shared constants and types for the versioned stack with roll back.
// ---------------------------------------------------------------------------
package vsr_pkg;

    // Capacity in items; node, item and table stores all have this depth
    localparam int MAX_ITEMS = 4096;
    // Node numbers and item counts run 0..MAX_ITEMS
    localparam int IDX_W     = $clog2(MAX_ITEMS + 1);
    // Store address, entry n held at n-1
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    // Fixed field widths
    localparam int VALUE_W   = 32;
    localparam int TARGET_W  = 13;
    localparam int CMD_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY    = 2'd0,
        CMD_PUSH     = 2'd1,
        CMD_POP      = 2'd2,
        CMD_ROLLBACK = 2'd3
    } cmd_t;

    // Controller to datapath commands
    typedef struct packed {
        logic issue;     // latch the item and start store reads
        logic exec;      // apply the item to the stack state
        logic load_out;  // load the result register
    } vsr_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic has_result; // current item returns a result
        logic out_busy;   // result register full and not taken this cycle
    } vsr_stat_t;

endpackage

// ===== sv/versioned_stack_with_rollback_core.sv =====
// ---------------------------------------------------------------------------
// versioned_stack_with_rollback_core
// Stack that keeps every earlier state; query, push, pop and roll back.
// ---------------------------------------------------------------------------
// Result: only queries and items past capacity return one; it is registered
//   after the store reads, later only while an earlier result waits on m_ready.
// Items: the next item waits until this one is applied, after the synchronous
//   read of the node, parent and history stores that follows each accept.
// Reset: aresetn synchronous, active low; empties the stack and clears the
//   item and node counts. Stores need no clearing pass.
// ---------------------------------------------------------------------------
module versioned_stack_with_rollback_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [vsr_pkg::CMD_W-1:0]            s_command,
    input  logic signed [vsr_pkg::VALUE_W-1:0]   s_push_value,
    input  logic [vsr_pkg::TARGET_W-1:0]         s_target_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [vsr_pkg::VALUE_W-1:0]   m_top_value,
    output logic                                 m_stack_empty,
    output logic                                 m_capacity_full
);

    vsr_pkg::vsr_ctrl_t ctrl;
    vsr_pkg::vsr_stat_t stat;

    // Controller
    vsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // Datapath
    vsr_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .stat            (stat),
        .s_command       (s_command),
        .s_push_value    (s_push_value),
        .s_target_item   (s_target_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_top_value     (m_top_value),
        .m_stack_empty   (m_stack_empty),
        .m_capacity_full (m_capacity_full)
    );

endmodule

// ===== sv/vsr_ctrl.sv =====
// ---------------------------------------------------------------------------
// vsr_ctrl
// Two-state controller: takes an item, then applies it once the store
// reads are back, holding while a result cannot be loaded.
// ---------------------------------------------------------------------------
module vsr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vsr_pkg::vsr_stat_t  stat,
    output vsr_pkg::vsr_ctrl_t  ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        ctrl          = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.issue = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!stat.has_result) begin
                    ctrl.exec  = 1'b1;
                    state_next = ST_IDLE;
                end else if (!stat.out_busy) begin
                    ctrl.exec     = 1'b1;
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/vsr_datapath.sv =====
// ---------------------------------------------------------------------------
// vsr_datapath
// Node, parent and top-history stores, stack state registers and the
// result register.
// ---------------------------------------------------------------------------
module vsr_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  vsr_pkg::vsr_ctrl_t                   ctrl,
    output vsr_pkg::vsr_stat_t                   stat,
    input  logic [vsr_pkg::CMD_W-1:0]            s_command,
    input  logic signed [vsr_pkg::VALUE_W-1:0]   s_push_value,
    input  logic [vsr_pkg::TARGET_W-1:0]         s_target_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [vsr_pkg::VALUE_W-1:0]   m_top_value,
    output logic                                 m_stack_empty,
    output logic                                 m_capacity_full
);

    localparam logic [vsr_pkg::IDX_W-1:0] MAX_COUNT = vsr_pkg::IDX_W'(vsr_pkg::MAX_ITEMS);
    localparam logic [vsr_pkg::IDX_W-1:0] IDX_ONE   = vsr_pkg::IDX_W'(1);

    // Stores
    logic signed [vsr_pkg::VALUE_W-1:0] node_values    [vsr_pkg::MAX_ITEMS];
    logic [vsr_pkg::IDX_W-1:0]          node_parents   [vsr_pkg::MAX_ITEMS];
    logic [vsr_pkg::IDX_W-1:0]          top_after_item [vsr_pkg::MAX_ITEMS];

    // Stack state
    logic [vsr_pkg::IDX_W-1:0] current_top_reg, current_top_next;
    logic [vsr_pkg::IDX_W-1:0] node_count_reg;
    logic [vsr_pkg::IDX_W-1:0] item_count_reg;

    // Latched item
    vsr_pkg::cmd_t                      cmd_reg;
    logic signed [vsr_pkg::VALUE_W-1:0] value_reg;
    logic [vsr_pkg::TARGET_W-1:0]       target_reg;
    logic                               full_reg;

    // Store read data
    logic signed [vsr_pkg::VALUE_W-1:0] rd_value_reg;
    logic [vsr_pkg::IDX_W-1:0]          rd_parent_reg;
    logic [vsr_pkg::IDX_W-1:0]          rd_hist_reg;

    logic                               m_valid_reg;

    logic [vsr_pkg::ADDR_W-1:0] top_addr;
    logic [vsr_pkg::ADDR_W-1:0] target_addr;
    logic [vsr_pkg::ADDR_W-1:0] node_addr;
    logic [vsr_pkg::ADDR_W-1:0] item_addr;
    logic                       top_empty;
    logic                       target_out;
    logic                       node_we;
    logic                       hist_we;

    // Addresses: entry n sits at n-1; history read is issued from the port
    assign top_addr    = vsr_pkg::ADDR_W'(current_top_reg - IDX_ONE);
    assign target_addr = vsr_pkg::ADDR_W'(s_target_item - vsr_pkg::TARGET_W'(1));
    assign node_addr   = vsr_pkg::ADDR_W'(node_count_reg);
    assign item_addr   = vsr_pkg::ADDR_W'(item_count_reg);
    assign top_empty   = (current_top_reg == '0);
    assign target_out  = (target_reg == '0) ||
                         (32'(target_reg) > 32'(item_count_reg));

    assign node_we = ctrl.exec && !full_reg && (cmd_reg == vsr_pkg::CMD_PUSH);
    assign hist_we = ctrl.exec && !full_reg;

    // Status to controller
    assign stat.has_result = full_reg || (cmd_reg == vsr_pkg::CMD_QUERY);
    assign stat.out_busy   = m_valid_reg && !m_ready;

    // Latch the item on accept
    always_ff @(posedge aclk) begin
        if (ctrl.issue) begin
            cmd_reg    <= vsr_pkg::cmd_t'(s_command);
            value_reg  <= s_push_value;
            target_reg <= s_target_item;
            full_reg   <= (item_count_reg == MAX_COUNT);
        end
    end

    // Node value store
    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_values[node_addr] <= value_reg;
        end
        if (ctrl.issue) begin
            rd_value_reg <= node_values[top_addr];
        end
    end

    // Node parent store
    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_parents[node_addr] <= current_top_reg;
        end
        if (ctrl.issue) begin
            rd_parent_reg <= node_parents[top_addr];
        end
    end

    // Top history store, indexed by item number
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            top_after_item[item_addr] <= current_top_next;
        end
        if (ctrl.issue) begin
            rd_hist_reg <= top_after_item[target_addr];
        end
    end

    // New top for the latched item
    always_comb begin
        unique case (cmd_reg)
            vsr_pkg::CMD_QUERY:    current_top_next = current_top_reg;
            vsr_pkg::CMD_PUSH:     current_top_next = node_count_reg + IDX_ONE;
            vsr_pkg::CMD_POP:      current_top_next = top_empty ? '0 : rd_parent_reg;
            vsr_pkg::CMD_ROLLBACK: current_top_next = target_out ? '0 : rd_hist_reg;
            default:               current_top_next = '0;
        endcase
    end

    // Stack state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_top_reg <= '0;
            node_count_reg  <= '0;
            item_count_reg  <= '0;
        end else if (hist_we) begin
            current_top_reg <= current_top_next;
            item_count_reg  <= item_count_reg + IDX_ONE;
            if (cmd_reg == vsr_pkg::CMD_PUSH) begin
                node_count_reg <= node_count_reg + IDX_ONE;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_top_value     <= top_empty ? '0 : rd_value_reg;
            m_stack_empty   <= top_empty;
            m_capacity_full <= full_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/vsr_checker.sv =====
// ---------------------------------------------------------------------------
// vsr_checker
// Port-level checks for the versioned stack core, bound to the top level.
// ---------------------------------------------------------------------------
module vsr_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [vsr_pkg::VALUE_W-1:0]   m_top_value,
    input logic                                 m_stack_empty,
    input logic                                 m_capacity_full
);

    // No result out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its fields
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_top_value)
            && $stable(m_stack_empty) && $stable(m_capacity_full))
        else $error("stalled result changed");

    // Empty stack always reports a zero top
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stack_empty |-> m_top_value == '0)
        else $error("empty stack with nonzero top");

    // Each accept is followed by a busy state in which s_ready is low
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken in back-to-back cycles");

endmodule

bind versioned_stack_with_rollback_core vsr_checker u_vsr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_top_value     (m_top_value),
    .m_stack_empty   (m_stack_empty),
    .m_capacity_full (m_capacity_full)
);

// ===== verif/versioned_stack_with_rollback_core_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// versioned_stack_with_rollback_core_test
// Self-checking bench for the versioned stack core. A directed opening hits
// empty-stack pops, roll backs to zero, to unreached and to recorded items,
// and extreme push values. Random command streams follow under several
// sender and receiver idling mixes.
// Every query result is compared against an in-bench model of the stack.
// ---------------------------------------------------------------------------
module versioned_stack_with_rollback_core_test;

    localparam int RANDOM_ITEMS   = 1550;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        vsr_pkg::cmd_t                       cmd;
        logic signed [vsr_pkg::VALUE_W-1:0]  value;
        logic [vsr_pkg::TARGET_W-1:0]        target;
    } stack_item_t;

    typedef struct packed {
        logic signed [vsr_pkg::VALUE_W-1:0]  top;
        logic                                empty;
        logic                                full;
    } top_result_t;

    // DUT ports
    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [vsr_pkg::CMD_W-1:0]           s_command = '0;
    logic signed [vsr_pkg::VALUE_W-1:0]  s_push_value = '0;
    logic [vsr_pkg::TARGET_W-1:0]        s_target_item = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [vsr_pkg::VALUE_W-1:0]  m_top_value;
    logic                                m_stack_empty;
    logic                                m_capacity_full;

    // Stimulus and scoreboard
    stack_item_t    pending_items[$];
    top_result_t    results_due[$];
    stack_item_t    next_item;
    logic           in_taken = 1'b0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             queued_count = 0;
    int             mismatch_count = 0;

    // Model state of the stack
    logic [vsr_pkg::VALUE_W-1:0] node_val[vsr_pkg::MAX_ITEMS];
    int                          node_par[vsr_pkg::MAX_ITEMS];
    int                          top_hist[vsr_pkg::MAX_ITEMS];
    int                          stack_top = 0;
    int                          nodes_made = 0;
    int                          items_done = 0;

    // Coverage tallies for the summary
    int n_push = 0, n_pop = 0, n_roll = 0, n_query = 0, n_full = 0, n_checked = 0;

    versioned_stack_with_rollback_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_push_value    (s_push_value),
        .s_target_item   (s_target_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_top_value     (m_top_value),
        .m_stack_empty   (m_stack_empty),
        .m_capacity_full (m_capacity_full)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Top of stack as a query would see it
    function automatic top_result_t current_top_result(input logic full);
        top_result_t r;
        r.full = full;
        if (stack_top != 0 && stack_top <= nodes_made) begin
            r.top   = node_val[stack_top-1];
            r.empty = 1'b0;
        end else begin
            r.top   = '0;
            r.empty = 1'b1;
        end
        return r;
    endfunction

    // Advance the stack model by one accepted item
    task automatic apply_stack_item(input vsr_pkg::cmd_t cmd,
                                    input logic [vsr_pkg::VALUE_W-1:0] value,
                                    input logic [vsr_pkg::TARGET_W-1:0] target);
        if (items_done >= vsr_pkg::MAX_ITEMS) begin
            // numbering exhausted: item ignored, top reported with full flag
            results_due.insert(results_due.size(), current_top_result(1'b1));
            n_full++;
        end else begin
            case (cmd)
                vsr_pkg::CMD_QUERY: begin
                    results_due.insert(results_due.size(), current_top_result(1'b0));
                    n_query++;
                end
                vsr_pkg::CMD_PUSH: begin
                    node_val[nodes_made] = value;
                    node_par[nodes_made] = stack_top;
                    nodes_made++;
                    stack_top = nodes_made;
                    n_push++;
                end
                vsr_pkg::CMD_POP: begin
                    // popping an empty stack leaves it empty
                    if (stack_top != 0 && stack_top <= nodes_made)
                        stack_top = node_par[stack_top-1];
                    else
                        stack_top = 0;
                    n_pop++;
                end
                default: begin
                    if (target == 0 || int'(target) > items_done)
                        stack_top = 0;
                    else
                        stack_top = top_hist[target-1];
                    n_roll++;
                end
            endcase
            top_hist[items_done] = stack_top;
            items_done++;
        end
    endtask

    // Compare one returned item with the oldest expected result
    task automatic check_top_result();
        top_result_t want;
        if (results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: unexpected result top=%0d empty=%0b full=%0b", $realtime,
                         m_top_value, m_stack_empty, m_capacity_full);
        end else begin
            want = results_due.pop_front();
            n_checked++;
            if (m_top_value !== want.top || m_stack_empty !== want.empty ||
                m_capacity_full !== want.full) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result mismatch: expected top=%0d empty=%0b full=%0b,",
                             $realtime, want.top, want.empty, want.full,
                             " got top=%0d empty=%0b full=%0b",
                             m_top_value, m_stack_empty, m_capacity_full);
            end
        end
    endtask

    // Driver: new item or idle at the falling edge, receiver stalls at random
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_items.pop_front();
                    s_valid       <= 1'b1;
                    s_command     <= next_item.cmd;
                    s_push_value  <= next_item.value;
                    s_target_item <= next_item.target;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check returned items, then model accepted ones
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready)
                check_top_result();
            if (s_valid && s_ready)
                apply_stack_item(vsr_pkg::cmd_t'(s_command), s_push_value, s_target_item);
        end
    end

    task automatic queue_item(input vsr_pkg::cmd_t cmd,
                              input logic [vsr_pkg::VALUE_W-1:0] value,
                              input logic [vsr_pkg::TARGET_W-1:0] target);
        stack_item_t it;
        it.cmd    = cmd;
        it.value  = value;
        it.target = target;
        pending_items.insert(pending_items.size(), it);
        queued_count++;
    endtask

    // Mostly growing stacks with roll backs into recorded history
    task automatic queue_random_item();
        int pick;
        logic [vsr_pkg::VALUE_W-1:0] value;
        logic [vsr_pkg::TARGET_W-1:0] target;
        pick = $urandom_range(99);
        case ($urandom_range(9))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            2:       value = '0;
            3:       value = '1;
            default: value = $urandom;
        endcase
        target = vsr_pkg::TARGET_W'($urandom_range(8191));
        if (pick < 35) begin
            queue_item(vsr_pkg::CMD_PUSH, value, target);
        end else if (pick < 55) begin
            queue_item(vsr_pkg::CMD_POP, value, target);
        end else if (pick < 82) begin
            queue_item(vsr_pkg::CMD_QUERY, value, target);
        end else begin
            pick = $urandom_range(99);
            if (pick < 70 && queued_count > 0)
                target = vsr_pkg::TARGET_W'($urandom_range(queued_count, 1));
            else if (pick < 80)
                target = '0;
            else if (pick < 90 && queued_count < vsr_pkg::MAX_ITEMS)
                target = vsr_pkg::TARGET_W'($urandom_range(vsr_pkg::MAX_ITEMS,
                                                           queued_count + 1));
            else
                target = vsr_pkg::TARGET_W'(vsr_pkg::MAX_ITEMS);
            queue_item(vsr_pkg::CMD_ROLLBACK, value, target);
        end
    endtask

    // Hold the sender until everything sent has been answered
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || results_due.size() > 0)
            @(posedge aclk);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) queue_random_item();
        wait_drained();
    endtask

    // Stimulus
    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed opening, no idling
        queue_item(vsr_pkg::CMD_QUERY,    32'd0,         13'd0);    // query on empty
        queue_item(vsr_pkg::CMD_POP,      32'd0,         13'd0);    // pop on empty
        queue_item(vsr_pkg::CMD_ROLLBACK, 32'd0,         13'd0);    // roll back to zero
        queue_item(vsr_pkg::CMD_PUSH,     32'h7FFF_FFFF, 13'd0);
        queue_item(vsr_pkg::CMD_PUSH,     32'h8000_0000, 13'h1FFF);
        queue_item(vsr_pkg::CMD_QUERY,    32'hFFFF_FFFF, 13'h1FFF);
        queue_item(vsr_pkg::CMD_POP,      32'hFFFF_FFFF, 13'd0);
        queue_item(vsr_pkg::CMD_QUERY,    32'd0,         13'd0);
        queue_item(vsr_pkg::CMD_PUSH,     32'hFFFF_FFFF, 13'd0);
        queue_item(vsr_pkg::CMD_PUSH,     32'd0,         13'd0);
        queue_item(vsr_pkg::CMD_QUERY,    32'd0,         13'd0);
        queue_item(vsr_pkg::CMD_ROLLBACK, 32'd0,         13'd4);    // back to one node
        queue_item(vsr_pkg::CMD_QUERY,    32'd0,         13'd0);
        queue_item(vsr_pkg::CMD_ROLLBACK, 32'd0,         13'd2000); // target not reached
        queue_item(vsr_pkg::CMD_QUERY,    32'd0,         13'd0);
        queue_item(vsr_pkg::CMD_ROLLBACK, 32'd0,         13'd11);
        queue_item(vsr_pkg::CMD_QUERY,    32'd0,         13'd0);
        queue_item(vsr_pkg::CMD_ROLLBACK, 32'd0,         13'd4096); // top bit of target
        queue_item(vsr_pkg::CMD_POP,      32'd0,         13'd0);
        queue_item(vsr_pkg::CMD_QUERY,    32'd0,         13'd0);
        queue_item(vsr_pkg::CMD_ROLLBACK, 32'd0,         13'd1);    // empty history entry
        queue_item(vsr_pkg::CMD_PUSH,     32'h5555_5555, 13'd0);
        queue_item(vsr_pkg::CMD_PUSH,     32'hAAAA_AAAA, 13'd0);
        queue_item(vsr_pkg::CMD_ROLLBACK, 32'd0,         13'd23);
        queue_item(vsr_pkg::CMD_QUERY,    32'd0,         13'd0);
        wait_drained();

        // Random streams under each idling mix
        run_random_phase(0,  0,  RANDOM_ITEMS / 4);
        run_random_phase(78, 0,  RANDOM_ITEMS / 4);
        run_random_phase(0,  78, RANDOM_ITEMS / 4);
        run_random_phase(20, 20, RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4));

        repeat (8) @(posedge aclk);
        $display("Ran %0d items: %0d pushes, %0d pops, %0d roll backs, %0d queries.",
                 items_done + n_full, n_push, n_pop, n_roll, n_query);
        $display("Checked %0d results, %0d of them past capacity; %0d mismatches.",
                 n_checked, n_full, mismatch_count);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop
    initial begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", results_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== versioned_stack_with_rollback_core.f =====
sv/vsr_pkg.sv
sv/vsr_ctrl.sv
sv/vsr_datapath.sv
sv/versioned_stack_with_rollback_core.sv
sv/vsr_checker.sv
verif/versioned_stack_with_rollback_core_test.sv
